FILE: design/qfct_pkg.sv
// Shared types, constants and width helpers for the quaternion frame chain transform.
`timescale 1ns / 1ps

package qfct_pkg;

    // Field widths
    localparam int QUAT_W  = 16;
    localparam int COORD_W = 32;

    // Default number of fraction bits in a quaternion component
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // Command codes
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    // Sequencer step numbering
    localparam int STEP_W = 5;
    // first step that captures a matrix entry (entries 0..8 on steps 1..9)
    localparam logic [STEP_W-1:0] STEP_MAT_CAP = 5'd1;
    localparam int                MAT_N        = 9;
    // rotated rows are captured on steps 11, 13, 15
    localparam logic [STEP_W-1:0] STEP_ROW_CAP = 5'd11;
    // quaternion product components are captured on steps 17, 19, 21, 23
    localparam logic [STEP_W-1:0] STEP_QP_CAP  = 5'd17;
    // last step of a point word and of a frame word
    localparam logic [STEP_W-1:0] STEP_PT_LAST = 5'd15;
    localparam logic [STEP_W-1:0] STEP_FR_LAST = 5'd23;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;    // update the accumulator
        logic load;  // start from the preset instead of the accumulator
    } t_mac_ctl;

    // Status from the sequencer to the top level
    typedef struct packed {
        logic busy;  // a word is being worked on
        logic emit;  // global point is handed to the output register
    } t_seq_stat;

    // Width of a rounded rotation matrix entry
    function automatic int mat_w(input int qf);
        int ew;
        ew = (2 * qf + 2 > 34) ? 2 * qf + 2 : 34;
        return ew + 1 - qf;
    endfunction

    // Width of the accumulator: three entry-by-coordinate products plus headroom
    function automatic int acc_w(input int qf);
        return mat_w(qf) + 34;
    endfunction

endpackage

FILE: design/qfct_mac.sv
// Shared two-product multiply-accumulate unit.
`timescale 1ns / 1ps

module qfct_mac #(
    parameter int OPA_W = 21,
    parameter int ACC_W = 55
) (
    input  logic                    i_clk,
    input  qfct_pkg::t_mac_ctl      i_ctl,
    input  logic signed [ACC_W-1:0] i_preset,
    input  logic signed [OPA_W-1:0] i_a0,
    input  logic signed [31:0]      i_b0,
    input  logic signed [OPA_W-1:0] i_a1,
    input  logic signed [31:0]      i_b1,
    output logic signed [ACC_W-1:0] o_acc
);
    import qfct_pkg::*;

    localparam int PW = OPA_W + 32;

    logic signed [PW-1:0]    w_p0;
    logic signed [PW-1:0]    w_p1;
    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] r_acc;

    // two products summed onto the preset or the running total
    assign w_p0   = i_a0 * i_b0;
    assign w_p1   = i_a1 * i_b1;
    assign w_base = i_ctl.load ? i_preset : r_acc;
    assign n_acc  = w_base + ACC_W'(w_p0) + ACC_W'(w_p1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: design/qfct_seq.sv
// Step sequencer with accumulated frame state, matrix store and rounding.
`timescale 1ns / 1ps

module qfct_seq #(
    parameter int QUAT_FRAC_BITS = qfct_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_command,
    input  logic signed [qfct_pkg::QUAT_W-1:0]   i_quat [4],
    input  logic signed [qfct_pkg::COORD_W-1:0]  i_vec [3],
    input  logic                                 i_out_free,
    output qfct_pkg::t_seq_stat                  o_stat,
    output logic signed [qfct_pkg::COORD_W-1:0]  o_point [3]
);
    import qfct_pkg::*;

    localparam int QF  = QUAT_FRAC_BITS;
    localparam int MW  = mat_w(QUAT_FRAC_BITS);
    localparam int ACW = acc_w(QUAT_FRAC_BITS);

    localparam logic signed [ACW-1:0] PRE_HALF = ACW'(1) << (QF - 1);
    localparam logic signed [ACW-1:0] PRE_ONE  = (ACW'(1) << (2 * QF)) + PRE_HALF;
    localparam logic signed [ACW-1:0] MAX32    = ACW'(32'sh7FFF_FFFF);
    localparam logic signed [ACW-1:0] MIN32    = ACW'(32'sh8000_0000);
    localparam logic signed [ACW-1:0] MAX16    = ACW'(16'sh7FFF);
    localparam logic signed [ACW-1:0] MIN16    = ACW'(16'sh8000);
    // identity w saturates when 1.0 does not fit the word
    localparam logic signed [QUAT_W-1:0] ID_W  =
        (QF >= QUAT_W - 1) ? 16'sh7FFF : QUAT_W'(1 << QF);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    t_state                    r_state;
    logic [STEP_W-1:0]         r_step;
    logic signed [QUAT_W-1:0]  r_rot   [4];
    logic signed [COORD_W-1:0] r_trans [3];
    logic signed [MW-1:0]      r_mat   [MAT_N];
    logic signed [COORD_W-1:0] r_rv    [3];
    logic signed [QUAT_W-1:0]  r_nq    [4];

    t_mac_ctl                  w_ctl;
    logic signed [ACW-1:0]     w_preset;
    logic signed [MW-1:0]      w_a0;
    logic signed [MW-1:0]      w_a1;
    logic signed [31:0]        w_b0;
    logic signed [31:0]        w_b1;
    logic signed [ACW-1:0]     w_acc;
    logic signed [ACW-1:0]     w_acc_sh;
    logic signed [MW-1:0]      w_mat;
    logic signed [COORD_W-1:0] w_row;
    logic signed [QUAT_W-1:0]  w_cq;
    logic                      w_is_point;
    logic                      w_last;

    // rotation components sign-extended, doubled, and as 32-bit multiplicands; frame quaternion as 32-bit multiplicands
    logic signed [MW-1:0] e_w, e_x, e_y, e_z;
    logic signed [MW-1:0] d_x, d_y, d_z;
    logic signed [31:0]   b_w, b_x, b_y, b_z;
    logic signed [31:0]   q_w, q_x, q_y, q_z;

    function automatic logic signed [COORD_W-1:0] sat_add32(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = (COORD_W + 1)'(a) + (COORD_W + 1)'(b);
        if (s[COORD_W] != s[COORD_W-1]) begin
            return s[COORD_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[COORD_W-1:0];
    endfunction

    assign e_w = MW'(r_rot[0]);
    assign e_x = MW'(r_rot[1]);
    assign e_y = MW'(r_rot[2]);
    assign e_z = MW'(r_rot[3]);
    assign d_x = e_x <<< 1;
    assign d_y = e_y <<< 1;
    assign d_z = e_z <<< 1;
    assign b_w = 32'(r_rot[0]);
    assign b_x = 32'(r_rot[1]);
    assign b_y = 32'(r_rot[2]);
    assign b_z = 32'(r_rot[3]);
    assign q_w = 32'(i_quat[0]);
    assign q_x = 32'(i_quat[1]);
    assign q_y = 32'(i_quat[2]);
    assign q_z = 32'(i_quat[3]);

    assign w_is_point = (i_command == CMD_POINT);
    assign w_last     = w_is_point ? (r_step == STEP_PT_LAST) : (r_step == STEP_FR_LAST);

    // operand selection per step: matrix entries, rotated rows, quaternion product
    always_comb begin
        w_ctl.en   = (r_state == S_RUN) && !w_last;
        w_ctl.load = 1'b1;
        w_preset   = PRE_HALF;
        w_a0       = '0;
        w_b0       = '0;
        w_a1       = '0;
        w_b1       = '0;
        unique case (r_step)
            5'd0: begin
                w_preset = PRE_ONE;
                w_a0 = -d_y; w_b0 = b_y; w_a1 = -d_z; w_b1 = b_z;
            end
            5'd1: begin w_a0 = d_x; w_b0 = b_y; w_a1 = -d_z; w_b1 = b_w; end
            5'd2: begin w_a0 = d_x; w_b0 = b_z; w_a1 = d_y;  w_b1 = b_w; end
            5'd3: begin w_a0 = d_x; w_b0 = b_y; w_a1 = d_z;  w_b1 = b_w; end
            5'd4: begin
                w_preset = PRE_ONE;
                w_a0 = -d_x; w_b0 = b_x; w_a1 = -d_z; w_b1 = b_z;
            end
            5'd5: begin w_a0 = d_y; w_b0 = b_z; w_a1 = -d_x; w_b1 = b_w; end
            5'd6: begin w_a0 = d_x; w_b0 = b_z; w_a1 = -d_y; w_b1 = b_w; end
            5'd7: begin w_a0 = d_y; w_b0 = b_z; w_a1 = d_x;  w_b1 = b_w; end
            5'd8: begin
                w_preset = PRE_ONE;
                w_a0 = -d_x; w_b0 = b_x; w_a1 = -d_y; w_b1 = b_y;
            end
            // rows: two products, then the third onto the running sum
            5'd9:  begin w_a0 = r_mat[0]; w_b0 = i_vec[0]; w_a1 = r_mat[1]; w_b1 = i_vec[1]; end
            5'd10: begin w_ctl.load = 1'b0; w_a0 = r_mat[2]; w_b0 = i_vec[2]; end
            5'd11: begin w_a0 = r_mat[3]; w_b0 = i_vec[0]; w_a1 = r_mat[4]; w_b1 = i_vec[1]; end
            5'd12: begin w_ctl.load = 1'b0; w_a0 = r_mat[5]; w_b0 = i_vec[2]; end
            5'd13: begin w_a0 = r_mat[6]; w_b0 = i_vec[0]; w_a1 = r_mat[7]; w_b1 = i_vec[1]; end
            5'd14: begin w_ctl.load = 1'b0; w_a0 = r_mat[8]; w_b0 = i_vec[2]; end
            // accumulated rotation times frame quaternion
            5'd15: begin w_a0 = e_w; w_b0 = q_w; w_a1 = -e_x; w_b1 = q_x; end
            5'd16: begin w_ctl.load = 1'b0; w_a0 = -e_y; w_b0 = q_y; w_a1 = -e_z; w_b1 = q_z; end
            5'd17: begin w_a0 = e_w; w_b0 = q_x; w_a1 = e_x; w_b1 = q_w; end
            5'd18: begin w_ctl.load = 1'b0; w_a0 = e_y; w_b0 = q_z; w_a1 = -e_z; w_b1 = q_y; end
            5'd19: begin w_a0 = e_w; w_b0 = q_y; w_a1 = -e_x; w_b1 = q_z; end
            5'd20: begin w_ctl.load = 1'b0; w_a0 = e_y; w_b0 = q_w; w_a1 = e_z; w_b1 = q_x; end
            5'd21: begin w_a0 = e_w; w_b0 = q_z; w_a1 = e_x; w_b1 = q_y; end
            5'd22: begin w_ctl.load = 1'b0; w_a0 = -e_y; w_b0 = q_x; w_a1 = e_z; w_b1 = q_w; end
            default: begin
                w_ctl.en = 1'b0;
            end
        endcase
    end

    qfct_mac #(
        .OPA_W (MW),
        .ACC_W (ACW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_preset (w_preset),
        .i_a0     (w_a0),
        .i_b0     (w_b0),
        .i_a1     (w_a1),
        .i_b1     (w_b1),
        .o_acc    (w_acc)
    );

    // rounding offset is already in the preset, so the shift finishes the rounding
    assign w_acc_sh = w_acc >>> QF;
    assign w_mat    = w_acc_sh[MW-1:0];

    always_comb begin
        priority if (w_acc_sh > MAX32) begin
            w_row = 32'sh7FFF_FFFF;
        end else if (w_acc_sh < MIN32) begin
            w_row = 32'sh8000_0000;
        end else begin
            w_row = w_acc_sh[COORD_W-1:0];
        end
    end

    always_comb begin
        priority if (w_acc_sh > MAX16) begin
            w_cq = 16'sh7FFF;
        end else if (w_acc_sh < MIN16) begin
            w_cq = 16'sh8000;
        end else begin
            w_cq = w_acc_sh[QUAT_W-1:0];
        end
    end

    // results of the previous step land in their stores
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            if (r_step >= STEP_MAT_CAP && r_step < STEP_MAT_CAP + STEP_W'(MAT_N)) begin
                r_mat[4'(r_step - STEP_MAT_CAP)] <= w_mat;
            end
            if (r_step[0] && r_step >= STEP_ROW_CAP && r_step <= STEP_PT_LAST) begin
                r_rv[2'((r_step - STEP_ROW_CAP) >> 1)] <= w_row;
            end
            if (r_step[0] && r_step >= STEP_QP_CAP) begin
                r_nq[2'((r_step - STEP_QP_CAP) >> 1)] <= w_cq;
            end
        end
    end

    // sequencer and accumulated frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_rot   <= '{ID_W, '0, '0, '0};
            r_trans <= '{'0, '0, '0};
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (w_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!w_is_point) begin
                        for (int i = 0; i < 3; i++) begin
                            r_trans[i] <= sat_add32(r_trans[i], r_rv[i]);
                        end
                        r_rot   <= r_nq;
                        r_state <= S_IDLE;
                    end else if (i_out_free) begin
                        r_rot   <= '{ID_W, '0, '0, '0};
                        r_trans <= '{'0, '0, '0};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // global point: accumulated translation plus rotated local point
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_point[i] = sat_add32(r_trans[i], r_rv[i]);
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.emit = (r_state == S_FINISH) && w_is_point && i_out_free;

endmodule

FILE: design/quaternion_frame_chain_transform.sv
// Top level of the quaternion frame chain transform: handshakes, input and output registers.
// Usage:
//   Input channel (i_valid / o_stall) takes one word per command. A frame word
//   (command 0) rotates its translation by the accumulated rotation, adds it to
//   the accumulated translation and right-multiplies the accumulated rotation
//   by its quaternion. A point word (command 1) maps the local point into the
//   global frame, sends it on the output channel and returns the accumulator
//   to the identity transform.
//   Output channel (o_valid / i_stall) carries one word per point word.
//   Timing: a single two-product multiply-accumulate unit does all products.
//   A frame word occupies 24 steps plus a commit state before the next word
//   is accepted; a point word takes 16 steps plus a finish state, in which
//   its result is handed to the output register.
//   o_stall is high while a word is being worked on and during reset.
//   A stalled output word holds; a finished point waits for the output
//   register to free before the next word is accepted.
//   Reset (synchronous, active low) sets the identity transform and empties
//   the output register.
`timescale 1ns / 1ps

module quaternion_frame_chain_transform #(
    parameter int QUAT_FRAC_BITS = qfct_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic signed [qfct_pkg::QUAT_W-1:0]  i_quat_w,
    input  logic signed [qfct_pkg::QUAT_W-1:0]  i_quat_x,
    input  logic signed [qfct_pkg::QUAT_W-1:0]  i_quat_y,
    input  logic signed [qfct_pkg::QUAT_W-1:0]  i_quat_z,
    input  logic signed [qfct_pkg::COORD_W-1:0] i_vec_x,
    input  logic signed [qfct_pkg::COORD_W-1:0] i_vec_y,
    input  logic signed [qfct_pkg::COORD_W-1:0] i_vec_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [qfct_pkg::COORD_W-1:0] o_out_x,
    output logic signed [qfct_pkg::COORD_W-1:0] o_out_y,
    output logic signed [qfct_pkg::COORD_W-1:0] o_out_z
);
    import qfct_pkg::*;

    logic                      r_cmd;
    logic signed [QUAT_W-1:0]  r_quat [4];
    logic signed [COORD_W-1:0] r_vec  [3];
    logic                      r_ovalid;
    logic signed [COORD_W-1:0] r_out  [3];

    t_seq_stat                 w_stat;
    logic                      w_accept;
    logic                      w_out_free;
    logic signed [COORD_W-1:0] w_point [3];

    assign o_stall    = w_stat.busy || !i_rst_n;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;

    // input word register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_quat <= '{i_quat_w, i_quat_x, i_quat_y, i_quat_z};
            r_vec  <= '{i_vec_x, i_vec_y, i_vec_z};
        end
    end

    qfct_seq #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_command  (r_cmd),
        .i_quat     (r_quat),
        .i_vec      (r_vec),
        .i_out_free (w_out_free),
        .o_stat     (w_stat),
        .o_point    (w_point)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_stat.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.emit) begin
            r_out <= w_point;
        end
    end

    assign o_valid = r_ovalid;
    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];

endmodule
